// ===== rtl/core/polygon_point_inside_and_winding_macros.svh =====
// Assertion macros used by the checker file.
`ifndef POLYGON_POINT_INSIDE_AND_WINDING_MACROS_SVH
`define POLYGON_POINT_INSIDE_AND_WINDING_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define PPW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is low.
`define PPW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ppw_pkg.sv =====
package ppw_pkg;

    localparam int MAX_VERTICES = 1024;

    localparam int COORD_W = 32;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int EXT_W   = 17;
    localparam int DIFF_W  = 33;
    localparam int HALF_W  = 17;
    localparam int PART_W  = 18;
    localparam int PROD_W  = DIFF_W + PART_W;
    localparam int ACC_W   = 77;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_INSIDE = 2'd1,
        CMD_WIND   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_OPEN  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_STEP,
        S_LOAD,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_DRAIN,
        S_DECIDE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                     go;
        logic                     clr;
        logic                     hi;
        logic                     sub;
        logic signed [DIFF_W-1:0] a;
        logic signed [DIFF_W-1:0] b;
    } t_mac_ctl;

    typedef struct packed {
        logic zero;
        logic neg;
    } t_mac_sts;

    typedef struct packed {
        logic on_edge;
        logic crosses;
    } t_edge_res;

endpackage

// ===== rtl/core/polygon_point_inside_and_winding.sv =====
// Point-in-polygon and winding unit over a store of linked vertices.
// Request channel: i_valid/o_ready with i_command, i_index, i_px, i_py, i_link.
// Command write stores one vertex; inside query tests (i_px, i_py) against the
// loop that starts at i_index; winding query reports a positive shoelace sum.
// Result channel: o_valid/i_ready with o_answer and o_status, one per request.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_vertex_count, always ready.
// Writes and unused commands go straight to the done state once accepted.
// A query reads its start vertex, then takes each edge through STEP, LOAD,
// MUL0 to MUL3 (inside) or MUL0 and MUL1 (winding), DRAIN and DECIDE, the
// MUL states driving the one shared 33x18-bit multiply-accumulate unit that
// forms each exact product in two halves.
// One request is in flight at a time; o_ready is low until its result is
// moved to the output register.
// A stalled result holds in the output register; a finished result waits for
// that register, so the block stalls in turn.
// Reset clears the sequencer, the output valid and vertex_count; vertex
// entries are undefined until written.
module polygon_point_inside_and_winding import ppw_pkg::*; #(
    parameter int P_MAX_VERTICES = MAX_VERTICES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_command,
    input  logic [IDX_W-1:0]          i_index,
    input  logic signed [COORD_W-1:0] i_px,
    input  logic signed [COORD_W-1:0] i_py,
    input  logic [IDX_W-1:0]          i_link,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_answer,
    output logic [1:0]                o_status,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CNT_W-1:0]          i_cfg_vertex_count
);

    localparam int AW = $clog2(P_MAX_VERTICES);
    localparam logic [EXT_W-1:0] LP_MAX = EXT_W'(P_MAX_VERTICES);

    t_state                    r_state;
    t_state                    n_state;
    logic [CNT_W-1:0]          r_cnt;
    logic [1:0]                r_cmd;
    logic [IDX_W-1:0]          r_start;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic [CNT_W-1:0]          r_limit;
    logic [CNT_W-1:0]          r_n;
    logic signed [COORD_W-1:0] r_x0;
    logic signed [COORD_W-1:0] r_y0;
    logic signed [COORD_W-1:0] r_x1;
    logic signed [COORD_W-1:0] r_y1;
    logic [IDX_W-1:0]          r_nxt;
    logic [IDX_W-1:0]          r_link1;
    logic signed [DIFF_W-1:0]  r_dx;
    logic signed [DIFF_W-1:0]  r_dy;
    logic signed [DIFF_W-1:0]  r_ax;
    logic signed [DIFF_W-1:0]  r_ay;
    logic signed [DIFF_W-1:0]  r_sy;
    logic                      r_par;
    logic                      r_res_ans;
    logic [1:0]                r_res_st;
    logic                      r_ovalid;
    logic                      r_oans;
    logic [1:0]                r_ost;

    logic                      accept;
    logic                      load_out;
    logic                      is_inside;
    logic                      range_err;
    logic                      walk_end;
    logic [EXT_W-1:0]          idx_ext;
    logic [EXT_W-1:0]          nxt_ext;
    logic [EXT_W-1:0]          cnt_ext;
    logic [CNT_W-1:0]          limit;
    logic                      we;
    logic [AW-1:0]             raddr;
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    logic [IDX_W-1:0]          rlink;
    t_mac_ctl                  mac_ctl;
    t_mac_sts                  mac_sts;
    t_edge_res                 edge_res;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign load_out    = (r_state == S_DONE) && (!r_ovalid || i_ready);
    assign is_inside   = (r_cmd == CMD_INSIDE);

    assign idx_ext   = {{(EXT_W-IDX_W){1'b0}}, i_index};
    assign nxt_ext   = {{(EXT_W-IDX_W){1'b0}}, r_nxt};
    assign cnt_ext   = {{(EXT_W-CNT_W){1'b0}}, r_cnt};
    assign limit     = (cnt_ext < LP_MAX) ? r_cnt : LP_MAX[CNT_W-1:0];
    assign range_err = (idx_ext >= cnt_ext) || (idx_ext >= LP_MAX);
    assign walk_end  = (r_n == r_limit) || (nxt_ext >= LP_MAX);
    assign we        = accept && (i_command == CMD_WRITE) && (idx_ext < LP_MAX);
    assign raddr     = (r_state == S_IDLE) ? idx_ext[AW-1:0] : nxt_ext[AW-1:0];

    ppw_store #(
        .P_DEPTH (P_MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wx    (i_px),
        .i_wy    (i_py),
        .i_wlink (i_link),
        .i_raddr (raddr),
        .o_rx    (rx),
        .o_ry    (ry),
        .o_rlink (rlink)
    );

    ppw_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .o_sts   (mac_sts)
    );

    ppw_edge u_edge (
        .i_px  (r_px),
        .i_py  (r_py),
        .i_x0  (r_x0),
        .i_y0  (r_y0),
        .i_x1  (r_x1),
        .i_y1  (r_y1),
        .i_dx  (r_dx),
        .i_dy  (r_dy),
        .i_d   (mac_sts),
        .o_res (edge_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_command == CMD_INSIDE) || (i_command == CMD_WIND)) begin
                        n_state = range_err ? S_DONE : S_FIRST;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FIRST:  n_state = S_STEP;
            S_STEP:   n_state = walk_end ? S_DONE : S_LOAD;
            S_LOAD:   n_state = S_MUL0;
            S_MUL0:   n_state = S_MUL1;
            S_MUL1:   n_state = is_inside ? S_MUL2 : S_DRAIN;
            S_MUL2:   n_state = S_MUL3;
            S_MUL3:   n_state = S_DRAIN;
            S_DRAIN:  n_state = S_DECIDE;
            S_DECIDE: begin
                if ((is_inside && edge_res.on_edge) || (r_nxt == r_start)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_DONE:   n_state = load_out ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mac_ctl = '{go: 1'b0, clr: 1'b0, hi: 1'b0, sub: 1'b0, a: r_dx, b: r_sy};
        case (r_state)
            S_IDLE: mac_ctl.clr = accept;
            S_LOAD: mac_ctl.clr = is_inside;
            S_MUL0: begin
                mac_ctl.go = 1'b1;
                mac_ctl.a  = is_inside ? r_ax : r_dx;
                mac_ctl.b  = is_inside ? r_dy : r_sy;
            end
            S_MUL1: begin
                mac_ctl.go = 1'b1;
                mac_ctl.hi = 1'b1;
                mac_ctl.a  = is_inside ? r_ax : r_dx;
                mac_ctl.b  = is_inside ? r_dy : r_sy;
            end
            S_MUL2: begin
                mac_ctl.go  = 1'b1;
                mac_ctl.sub = 1'b1;
                mac_ctl.a   = r_ay;
                mac_ctl.b   = r_dx;
            end
            S_MUL3: begin
                mac_ctl.go  = 1'b1;
                mac_ctl.hi  = 1'b1;
                mac_ctl.sub = 1'b1;
                mac_ctl.a   = r_ay;
                mac_ctl.b   = r_dx;
            end
            default: mac_ctl.go = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cnt <= i_cfg_vertex_count;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_oans <= r_res_ans;
            r_ost  <= r_res_st;
        end
        case (r_state)
            S_IDLE: begin
                r_cmd     <= i_command;
                r_start   <= i_index;
                r_px      <= i_px;
                r_py      <= i_py;
                r_limit   <= limit;
                r_n       <= '0;
                r_par     <= 1'b0;
                r_res_ans <= 1'b0;
                r_res_st  <= (((i_command == CMD_INSIDE) || (i_command == CMD_WIND))
                              && range_err) ? ST_RANGE : ST_OK;
            end
            S_FIRST: begin
                r_x0  <= rx;
                r_y0  <= ry;
                r_nxt <= rlink;
            end
            S_STEP: begin
                if (walk_end) begin
                    r_res_ans <= 1'b0;
                    r_res_st  <= ST_OPEN;
                end
            end
            S_LOAD: begin
                r_x1    <= rx;
                r_y1    <= ry;
                r_link1 <= rlink;
                r_dx    <= DIFF_W'(rx) - DIFF_W'(r_x0);
                r_dy    <= DIFF_W'(ry) - DIFF_W'(r_y0);
                r_ax    <= DIFF_W'(r_px) - DIFF_W'(r_x0);
                r_ay    <= DIFF_W'(r_py) - DIFF_W'(r_y0);
                r_sy    <= DIFF_W'(r_y0) + DIFF_W'(ry);
            end
            S_DECIDE: begin
                r_x0  <= r_x1;
                r_y0  <= r_y1;
                r_nxt <= r_link1;
                r_n   <= r_n + 1'b1;
                r_par <= r_par ^ edge_res.crosses;
                if (is_inside && edge_res.on_edge) begin
                    r_res_ans <= 1'b1;
                    r_res_st  <= ST_OK;
                end else if (r_nxt == r_start) begin
                    r_res_ans <= is_inside ? (r_par ^ edge_res.crosses)
                                           : (!mac_sts.neg && !mac_sts.zero);
                    r_res_st  <= ST_OK;
                end
            end
            default: r_n <= r_n;
        endcase
    end

    assign o_valid  = r_ovalid;
    assign o_answer = r_oans;
    assign o_status = r_ost;

endmodule

// ===== rtl/core/ppw_store.sv =====
module ppw_store import ppw_pkg::*; #(
    parameter int P_DEPTH = MAX_VERTICES
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic signed [COORD_W-1:0] i_wx,
    input  logic signed [COORD_W-1:0] i_wy,
    input  logic [IDX_W-1:0]          i_wlink,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic signed [COORD_W-1:0] o_rx,
    output logic signed [COORD_W-1:0] o_ry,
    output logic [IDX_W-1:0]          o_rlink
);

    logic signed [COORD_W-1:0] r_mem_x    [P_DEPTH];
    logic signed [COORD_W-1:0] r_mem_y    [P_DEPTH];
    logic [IDX_W-1:0]          r_mem_link [P_DEPTH];
    logic signed [COORD_W-1:0] r_rx;
    logic signed [COORD_W-1:0] r_ry;
    logic [IDX_W-1:0]          r_rlink;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_x[i_waddr]    <= i_wx;
            r_mem_y[i_waddr]    <= i_wy;
            r_mem_link[i_waddr] <= i_wlink;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx    <= r_mem_x[i_raddr];
        r_ry    <= r_mem_y[i_raddr];
        r_rlink <= r_mem_link[i_raddr];
    end

    assign o_rx    = r_rx;
    assign o_ry    = r_ry;
    assign o_rlink = r_rlink;

endmodule

// ===== rtl/core/ppw_mac.sv =====
module ppw_mac import ppw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mac_ctl i_ctl,
    output t_mac_sts o_sts
);

    logic signed [PART_W-1:0] bpart;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic                     r_hi;
    logic                     r_sub;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  term_ext;
    logic signed [ACC_W-1:0]  term;

    always_comb begin
        if (i_ctl.hi) begin
            bpart = {{(PART_W-(DIFF_W-HALF_W)){i_ctl.b[DIFF_W-1]}}, i_ctl.b[DIFF_W-1:HALF_W]};
        end else begin
            bpart = {{(PART_W-HALF_W){1'b0}}, i_ctl.b[HALF_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_ctl.a * bpart;
        r_hi   <= i_ctl.hi;
        r_sub  <= i_ctl.sub;
    end

    assign term_ext = ACC_W'(r_prod);
    assign term     = r_hi ? (term_ext <<< HALF_W) : term_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_sub ? (r_acc - term) : (r_acc + term);
        end
    end

    assign o_sts.zero = (r_acc == '0);
    assign o_sts.neg  = r_acc[ACC_W-1];

endmodule

// ===== rtl/core/ppw_edge.sv =====
module ppw_edge import ppw_pkg::*; (
    input  logic signed [COORD_W-1:0] i_px,
    input  logic signed [COORD_W-1:0] i_py,
    input  logic signed [COORD_W-1:0] i_x0,
    input  logic signed [COORD_W-1:0] i_y0,
    input  logic signed [COORD_W-1:0] i_x1,
    input  logic signed [COORD_W-1:0] i_y1,
    input  logic signed [DIFF_W-1:0]  i_dx,
    input  logic signed [DIFF_W-1:0]  i_dy,
    input  t_mac_sts                  i_d,
    output t_edge_res                 o_res
);

    logic [DIFF_W-1:0] adx;
    logic [DIFF_W-1:0] ady;
    logic              in_range;
    logic              dx_pos;
    logic              dy_pos;
    logic              c_ok;

    assign adx    = i_dx[DIFF_W-1] ? DIFF_W'(-i_dx) : DIFF_W'(i_dx);
    assign ady    = i_dy[DIFF_W-1] ? DIFF_W'(-i_dy) : DIFF_W'(i_dy);
    assign dx_pos = !i_dx[DIFF_W-1] && (i_dx != '0);
    assign dy_pos = !i_dy[DIFF_W-1] && (i_dy != '0);

    always_comb begin
        if (adx >= ady) begin
            if (dx_pos) begin
                in_range = (i_x0 <= i_px) && (i_px <= i_x1);
            end else begin
                in_range = (i_x1 <= i_px) && (i_px <= i_x0);
            end
        end else begin
            if (dy_pos) begin
                in_range = (i_y0 <= i_py) && (i_py <= i_y1);
            end else begin
                in_range = (i_y1 <= i_py) && (i_py <= i_y0);
            end
        end
    end

    assign c_ok = dy_pos ? (i_d.neg || i_d.zero) : !i_d.neg;

    always_comb begin
        o_res.on_edge = i_d.zero && in_range;
        if ((i_y0 >= i_py) && (i_y1 >= i_py)) begin
            o_res.crosses = 1'b0;
        end else if ((i_y0 < i_py) && (i_y1 < i_py)) begin
            o_res.crosses = 1'b0;
        end else if ((i_x0 < i_px) && (i_x1 < i_px)) begin
            o_res.crosses = 1'b0;
        end else if (i_dy == '0) begin
            o_res.crosses = 1'b0;
        end else if (i_dx == '0) begin
            o_res.crosses = 1'b1;
        end else begin
            o_res.crosses = c_ok;
        end
    end

endmodule

// ===== rtl/core/ppw_checker.sv =====
`include "polygon_point_inside_and_winding_macros.svh"

module ppw_checker import ppw_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_answer,
    input logic [1:0] o_status
);

    `PPW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_answer) && $stable(o_status), "result changed while stalled")

    `PPW_ASSERT_NOW(a_err_no_answer, i_clk, i_rst_n, o_valid && (o_status != ST_OK),
        !o_answer, "error result carries a set answer")

    `PPW_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_valid && o_ready,
        !o_ready, "ready right after an accepted request")

endmodule

bind polygon_point_inside_and_winding ppw_checker u_ppw_checker (.*);
